/* sv/rbsi_pkg.sv */
// shared types and constants for the ray/box slab intersection block
// no dependencies; used by the interfaces, the divider and the top level
package rbsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int Q_W           = 32;
	localparam int HALF_W        = 31;
	localparam int CFG_IDX_W     = 2;
	localparam int AXES          = 3;
	// one stage for the range check, one per quotient bit
	localparam int DIV_STAGES    = Q_W + 1;

	localparam logic [HALF_W-1:0]     HALF_RESET = HALF_W'(32768);
	localparam logic signed [Q_W-1:0] Q_MAX      = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_MIN      = {1'b1, {(Q_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_X = 2'd0,
		CFG_HALF_Y = 2'd1,
		CFG_HALF_Z = 2'd2
	} cfg_idx_t;

	// per-request data that rides beside the dividers
	typedef struct packed {
		logic [AXES-1:0][Q_W-1:0] org;
		logic [AXES-1:0][Q_W-1:0] dir;
		logic [AXES-1:0]          neg0;
		logic [AXES-1:0]          neg1;
		logic [AXES-1:0]          zdir;
		logic                     in_slabs;
	} side_t;

endpackage

/* sv/rbsi_if.sv */
// valid/ready channels for ray requests and intersection results
// depends on rbsi_pkg
interface rbsi_ray_if import rbsi_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] origin_x;
	logic signed [Q_W-1:0] origin_y;
	logic signed [Q_W-1:0] origin_z;
	logic signed [Q_W-1:0] dir_x;
	logic signed [Q_W-1:0] dir_y;
	logic signed [Q_W-1:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rbsi_res_if import rbsi_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic signed [Q_W-1:0] point_x;
	logic signed [Q_W-1:0] point_y;
	logic signed [Q_W-1:0] point_z;

	modport source (output valid, hit, point_x, point_y, point_z, input ready);
	modport sink (input valid, hit, point_x, point_y, point_z, output ready);
endinterface

/* sv/rbsi_div.sv */
// pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage
// depends on rbsi_pkg; stage enables come from the top level's stall chain
module rbsi_div import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [Q_W-1:0]        num,
	input  logic [Q_W-1:0]        den,
	output logic [Q_W-1:0]        quo,
	output logic                  ovf
);

	logic [Q_W-1:0] rem_sd [DIV_STAGES];
	logic [Q_W-1:0] lo_sd  [DIV_STAGES];
	logic [Q_W-1:0] den_sd [DIV_STAGES];
	logic [Q_W-1:0] q_sd   [DIV_STAGES];
	logic           ovf_sd [DIV_STAGES];

	logic [Q_W-1:0] hi0;

	// high dividend bits; quotient needs more than Q_W bits when they reach den
	assign hi0 = {{(Q_W-FRAC_BITS){1'b0}}, num[Q_W-1 -: FRAC_BITS]};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_sd[0] <= hi0;
			lo_sd[0]  <= {num[Q_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			den_sd[0] <= den;
			q_sd[0]   <= '0;
			ovf_sd[0] <= (hi0 >= den);
		end
	end

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
		logic [Q_W:0] trial;
		logic [Q_W:0] diff;
		logic         ge;

		assign trial = {rem_sd[k-1], lo_sd[k-1][Q_W-1]};
		assign diff  = trial - {1'b0, den_sd[k-1]};
		assign ge    = (trial >= {1'b0, den_sd[k-1]});

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_sd[k] <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
				lo_sd[k]  <= {lo_sd[k-1][Q_W-2:0], 1'b0};
				den_sd[k] <= den_sd[k-1];
				q_sd[k]   <= {q_sd[k-1][Q_W-2:0], ge};
				ovf_sd[k] <= ovf_sd[k-1];
			end
		end
	end

	assign quo = q_sd[DIV_STAGES-1];
	assign ovf = ovf_sd[DIV_STAGES-1];

endmodule

/* sv/ray_box_slab_intersect.sv */
// ray against origin-centered box, slab test in signed fixed point
// pipeline: 1 input, 33 divider, 6 finishing stages; one request per cycle unless
// all stages are full and res.ready is low; each stage stalls only when its successor
// is full; the six slab dividers (one quotient bit per stage) set the depth
// reset: asynchronous, clears all stage valid bits, half extents return to 0.5
module ray_box_slab_intersect import rbsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [HALF_W-1:0]    wr_data,
	rbsi_ray_if.sink             ray,
	rbsi_res_if.source           res
);

	// stage map: 0 input, 1..DIV_STAGES divider, then six finishing stages
	localparam int P1 = DIV_STAGES + 1;
	localparam int NS = DIV_STAGES + 7;

	// configuration registers
	logic [HALF_W-1:0] half_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) half_q[a] <= HALF_RESET;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_HALF_X: half_q[0] <= wr_data;
				CFG_HALF_Y: half_q[1] <= wr_data;
				CFG_HALF_Z: half_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	// valid bits and stall chain: a stage loads when empty or when it drains
	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !v_q[NS-1] || res.ready;
		for (int k = NS-2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
	end

	assign ray.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= ray.valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// stage 1: slab numerators, signs, zero-direction checks
	logic signed [Q_W-1:0] org_in [AXES];
	logic signed [Q_W-1:0] dir_in [AXES];

	assign org_in[0] = ray.origin_x;
	assign org_in[1] = ray.origin_y;
	assign org_in[2] = ray.origin_z;
	assign dir_in[0] = ray.dir_x;
	assign dir_in[1] = ray.dir_y;
	assign dir_in[2] = ray.dir_z;

	logic [Q_W-1:0]   num0m_s1 [AXES];
	logic [Q_W-1:0]   num1m_s1 [AXES];
	logic [Q_W-1:0]   denm_s1  [AXES];
	side_t            side_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int a = 0; a < AXES; a++) begin
				logic signed [Q_W+1:0] h;
				logic signed [Q_W+1:0] o;
				logic signed [Q_W+1:0] n0;
				logic signed [Q_W+1:0] n1;
				logic signed [Q_W+1:0] dm;
				h  = $signed({3'b000, half_q[a]});
				o  = (Q_W+2)'(org_in[a]);
				n0 = -h - o;
				n1 = h - o;
				dm = (Q_W+2)'(dir_in[a]);
				if (dm < 0) dm = -dm;
				num0m_s1[a] <= (n0 < 0) ? Q_W'(-n0) : Q_W'(n0);
				num1m_s1[a] <= (n1 < 0) ? Q_W'(-n1) : Q_W'(n1);
				denm_s1[a]  <= dm[Q_W-1:0];
				side_s1.org[a]  <= org_in[a];
				side_s1.dir[a]  <= dir_in[a];
				side_s1.neg0[a] <= (n0 < 0) != dir_in[a][Q_W-1];
				side_s1.neg1[a] <= (n1 < 0) != dir_in[a][Q_W-1];
				side_s1.zdir[a] <= (dir_in[a] == '0);
			end
			// zero-direction axes must hold the origin inside the slab, faces count
			side_s1.in_slabs <=
				!((dir_in[0] == '0) && ((Q_W+2)'(org_in[0]) < -$signed({3'b000, half_q[0]}) ||
					(Q_W+2)'(org_in[0]) > $signed({3'b000, half_q[0]}))) &&
				!((dir_in[1] == '0) && ((Q_W+2)'(org_in[1]) < -$signed({3'b000, half_q[1]}) ||
					(Q_W+2)'(org_in[1]) > $signed({3'b000, half_q[1]}))) &&
				!((dir_in[2] == '0) && ((Q_W+2)'(org_in[2]) < -$signed({3'b000, half_q[2]}) ||
					(Q_W+2)'(org_in[2]) > $signed({3'b000, half_q[2]})));
		end
	end

	// dividers: near and far slab parameter per axis
	logic [Q_W-1:0] q0 [AXES];
	logic [Q_W-1:0] q1 [AXES];
	logic [AXES-1:0] ovf0;
	logic [AXES-1:0] ovf1;

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
			.clk (clk),
			.en  (en[DIV_STAGES:1]),
			.num (num0m_s1[a]),
			.den (denm_s1[a]),
			.quo (q0[a]),
			.ovf (ovf0[a])
		);
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
			.clk (clk),
			.en  (en[DIV_STAGES:1]),
			.num (num1m_s1[a]),
			.den (denm_s1[a]),
			.quo (q1[a]),
			.ovf (ovf1[a])
		);
	end

	// side data delay line matching the divider depth
	side_t side_sd [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en[1]) side_sd[0] <= side_s1;
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (en[k+1]) side_sd[k] <= side_sd[k-1];
		end
	end

	// signed saturation of an unsigned quotient
	function automatic logic signed [Q_W-1:0] sat_q(input logic [Q_W-1:0] q,
		input logic ov, input logic neg);
		if (neg) begin
			if (ov || (q > {1'b1, {(Q_W-1){1'b0}}})) return Q_MIN;
			return -$signed(q);
		end
		if (ov || q[Q_W-1]) return Q_MAX;
		return $signed(q);
	endfunction

	// finishing stage 2: signed, saturated slab parameters
	logic signed [Q_W-1:0] t0_s2 [AXES];
	logic signed [Q_W-1:0] t1_s2 [AXES];
	side_t                 side_s2;

	always_ff @(posedge clk) begin
		if (en[P1]) begin
			for (int a = 0; a < AXES; a++) begin
				t0_s2[a] <= sat_q(q0[a], ovf0[a], side_sd[DIV_STAGES-1].neg0[a]);
				t1_s2[a] <= sat_q(q1[a], ovf1[a], side_sd[DIV_STAGES-1].neg1[a]);
			end
			side_s2 <= side_sd[DIV_STAGES-1];
		end
	end

	// stage 3: order each pair, zero-direction axes impose no limit
	logic signed [Q_W-1:0] lo_s3 [AXES];
	logic signed [Q_W-1:0] hi_s3 [AXES];
	side_t                 side_s3;

	always_ff @(posedge clk) begin
		if (en[P1+1]) begin
			for (int a = 0; a < AXES; a++) begin
				if (side_s2.zdir[a]) begin
					lo_s3[a] <= '0;
					hi_s3[a] <= Q_MAX;
				end else if (t0_s2[a] > t1_s2[a]) begin
					lo_s3[a] <= t1_s2[a];
					hi_s3[a] <= t0_s2[a];
				end else begin
					lo_s3[a] <= t0_s2[a];
					hi_s3[a] <= t1_s2[a];
				end
			end
			side_s3 <= side_s2;
		end
	end

	// stage 4: interval clip; tmin starts at 0, tmax at the largest value
	logic signed [Q_W-1:0] tmin_s4;
	logic signed [Q_W-1:0] tmax_s4;
	side_t                 side_s4;
	logic signed [Q_W-1:0] mx01, mx2, mn01;

	always_comb begin
		mx01 = (lo_s3[0] > lo_s3[1]) ? lo_s3[0] : lo_s3[1];
		mx2  = (lo_s3[2] > 0) ? lo_s3[2] : '0;
		mn01 = (hi_s3[0] < hi_s3[1]) ? hi_s3[0] : hi_s3[1];
	end

	always_ff @(posedge clk) begin
		if (en[P1+2]) begin
			tmin_s4 <= (mx01 > mx2) ? mx01 : mx2;
			tmax_s4 <= (mn01 < hi_s3[2]) ? mn01 : hi_s3[2];
			side_s4 <= side_s3;
		end
	end

	// stage 5: hit decision, direction magnitudes
	logic                  hit_s5;
	logic [HALF_W-1:0]     tmin_s5;
	logic [Q_W-1:0]        dirm_s5 [AXES];
	logic [AXES-1:0]       dneg_s5;
	logic [AXES-1:0][Q_W-1:0] org_s5;

	always_ff @(posedge clk) begin
		if (en[P1+3]) begin
			hit_s5  <= side_s4.in_slabs && (tmin_s4 <= tmax_s4);
			tmin_s5 <= tmin_s4[HALF_W-1:0];
			for (int a = 0; a < AXES; a++) begin
				dneg_s5[a] <= side_s4.dir[a][Q_W-1];
				dirm_s5[a] <= side_s4.dir[a][Q_W-1] ? (~side_s4.dir[a] + 1'b1) :
					side_s4.dir[a];
			end
			org_s5 <= side_s4.org;
		end
	end

	// stage 6: |dir| * tmin, exact
	logic                     hit_s6;
	logic [Q_W+HALF_W-1:0]    prod_s6 [AXES];
	logic [AXES-1:0]          dneg_s6;
	logic [AXES-1:0][Q_W-1:0] org_s6;

	always_ff @(posedge clk) begin
		if (en[P1+4]) begin
			hit_s6 <= hit_s5;
			for (int a = 0; a < AXES; a++) begin
				prod_s6[a] <= (Q_W+HALF_W)'(dirm_s5[a]) * (Q_W+HALF_W)'(tmin_s5);
			end
			dneg_s6 <= dneg_s5;
			org_s6  <= org_s5;
		end
	end

	// stage 7: scale, apply sign, add origin, saturate, zero a miss; output register
	logic                  hit_s7;
	logic signed [Q_W-1:0] point_s7 [AXES];

	always_ff @(posedge clk) begin
		if (en[P1+5]) begin
			hit_s7 <= hit_s6;
			for (int a = 0; a < AXES; a++) begin
				logic signed [2*Q_W-1:0] p;
				logic signed [2*Q_W-1:0] sum;
				p   = $signed((2*Q_W)'(prod_s6[a] >> FRAC_BITS));
				sum = (2*Q_W)'($signed(org_s6[a])) + (dneg_s6[a] ? -p : p);
				if (!hit_s6)                       point_s7[a] <= '0;
				else if (sum > (2*Q_W)'(Q_MAX))    point_s7[a] <= Q_MAX;
				else if (sum < (2*Q_W)'(Q_MIN))    point_s7[a] <= Q_MIN;
				else                               point_s7[a] <= sum[Q_W-1:0];
			end
		end
	end

	assign res.valid   = v_q[NS-1];
	assign res.hit     = hit_s7;
	assign res.point_x = point_s7[0];
	assign res.point_y = point_s7[1];
	assign res.point_z = point_s7[2];

	// a miss reports a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.hit |-> res.point_x == '0 && res.point_y == '0 &&
			res.point_z == '0)
		else $error("miss with nonzero point");

	// requests are refused only when the whole pipe is full and the output stalls
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!ray.ready |-> (&v_q) && !res.ready)
		else $error("request refused with room in the pipe");

	// a stalled result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(hit_s7))
		else $error("stalled result lost");

endmodule
